// ----- rtl/sef16_pkg.sv -----
// types, constants and helpers shared by the envelope framer/checker
// no dependencies
`timescale 1ns / 1ps

package sef16_pkg;

  localparam int unsigned HDR_LEN    = 8;
  localparam int unsigned HDR_IDX_W  = $clog2(HDR_LEN);
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0] HDR_MAGIC0 = 8'h44;
  localparam logic [7:0] HDR_MAGIC1 = 8'h53;
  localparam logic [7:0] HDR_FLAGS  = 8'h00;
  localparam logic [7:0] MOD_BASE   = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       status;
    logic       final_res;
  } out_item_t;

  typedef struct packed {
    logic             mode;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       format_version;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       burst;
    logic       err;
    logic [7:0] sum_low;
    logic [7:0] sum_high;
  } res_req_t;

  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD_BASE}) begin
      s = s - {1'b0, MOD_BASE};
    end
    return s[7:0];
  endfunction

endpackage

// ----- rtl/save_envelope_fletcher16_core.sv -----
// an accepted byte is registered into stage 1; any results it causes are registered into the result register
// throughput: one byte per cycle while no byte waits; a build burst holds the output
// for its eight header bytes, and a byte that causes results waits until the result register is free
// reset: asynchronous, active low; clears config to check mode, length 1, version 1
// depends on sef16_pkg, sef16_engine, sef16_emitter
`timescale 1ns / 1ps

module save_envelope_fletcher16_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sef16_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sef16_pkg::out_item_t                out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sef16_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sef16_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  sef16_pkg::cfg_t     cfg_q;
  sef16_pkg::in_item_t s1_item_q;
  sef16_pkg::res_req_t req;
  logic                s1_valid_q, s1_valid_d;
  logic                fire, produces, emit_free, in_take, cfg_write;

  assign cfg_ready_o = !s1_valid_q && !out_valid_o;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign fire        = s1_valid_q && (!produces || emit_free);
  assign in_stall_o  = s1_valid_q && !fire;
  assign in_take     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_take || (s1_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q           <= 1'b0;
      cfg_q.mode           <= 1'b0;
      cfg_q.payload_length <= 16'd1;
      cfg_q.format_version <= 8'd1;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_write) begin
        unique case (cfg_index_i)
          sef16_pkg::CFG_MODE:    cfg_q.mode           <= cfg_data_i[0];
          sef16_pkg::CFG_LENGTH:  cfg_q.payload_length <= cfg_data_i;
          sef16_pkg::CFG_VERSION: cfg_q.format_version <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_data_i;
    end
  end

  sef16_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_write_i (cfg_write),
    .item_i      (s1_item_q),
    .fire_i      (fire),
    .produces_o  (produces),
    .req_o       (req)
  );

  sef16_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/sef16_engine.sv -----
// run state: byte count, fletcher sums, header capture and result decision
// depends on sef16_pkg
`timescale 1ns / 1ps

module sef16_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sef16_pkg::cfg_t     cfg_i,
  input  logic                cfg_write_i,
  input  sef16_pkg::in_item_t item_i,
  input  logic                fire_i,
  output logic                produces_o,
  output sef16_pkg::res_req_t req_o
);

  localparam logic [1:0] PH_COLLECT = 2'd0;
  localparam logic [1:0] PH_DRAIN   = 2'd1;

  logic [1:0]                     phase_q, phase_d;
  logic [sef16_pkg::CNT_W-1:0]    cnt_q, cnt_d, cnt_inc, expected;
  logic [7:0]                     lo_q, lo_d, hi_q, hi_d;
  logic [7:0]                     lo_add, hi_add, lo_new, hi_new;
  logic [7:0]                     hs_q   [sef16_pkg::HDR_LEN];
  logic [7:0]                     hs_eff [sef16_pkg::HDR_LEN];
  logic [sef16_pkg::HDR_IDX_W-1:0] hs_idx;
  logic                           hs_we, hdr_wr_en, zero_build, done, bad;

  always_comb begin
    hs_idx     = cnt_q[sef16_pkg::HDR_IDX_W-1:0];
    hdr_wr_en  = !cfg_i.mode && (cnt_q[sef16_pkg::CNT_W-1:sef16_pkg::HDR_IDX_W] == '0);
    zero_build = cfg_i.mode && (cfg_i.payload_length == '0);
    lo_add     = sef16_pkg::add_mod255(lo_q, item_i.data_byte);
    hi_add     = sef16_pkg::add_mod255(hi_q, lo_add);
    lo_new     = hdr_wr_en ? lo_q : lo_add;
    hi_new     = hdr_wr_en ? hi_q : hi_add;
    cnt_inc    = cnt_q + 17'd1;
    expected   = cfg_i.mode ? {1'b0, cfg_i.payload_length}
                            : {1'b0, cfg_i.payload_length} + 17'(sef16_pkg::HDR_LEN);
    done       = (cnt_inc == expected);
    for (int k = 0; k < sef16_pkg::HDR_LEN; k++) begin
      hs_eff[k] = (hdr_wr_en && hs_idx == sef16_pkg::HDR_IDX_W'(k)) ? item_i.data_byte
                                                                    : hs_q[k];
    end
    bad = (hs_eff[0] != sef16_pkg::HDR_MAGIC0) ||
          (hs_eff[1] != sef16_pkg::HDR_MAGIC1) ||
          (hs_eff[2] != cfg_i.format_version) ||
          (hs_eff[4] != cfg_i.payload_length[7:0]) ||
          (hs_eff[5] != cfg_i.payload_length[15:8]) ||
          (hs_eff[6] != lo_new) ||
          (hs_eff[7] != hi_new);
  end

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    hs_we      = 1'b0;
    produces_o = 1'b0;
    req_o      = '0;
    unique case (phase_q)
      PH_COLLECT: begin
        if (zero_build) begin
          produces_o = 1'b1;
          req_o.err  = 1'b1;
          if (fire_i) begin
            cnt_d   = '0;
            lo_d    = '0;
            hi_d    = '0;
            phase_d = item_i.last_byte ? PH_COLLECT : PH_DRAIN;
          end
        end else if (done) begin
          produces_o     = 1'b1;
          req_o.burst    = cfg_i.mode;
          req_o.err      = !cfg_i.mode && bad;
          req_o.sum_low  = lo_new;
          req_o.sum_high = hi_new;
          if (fire_i) begin
            hs_we   = hdr_wr_en;
            cnt_d   = '0;
            lo_d    = '0;
            hi_d    = '0;
            phase_d = item_i.last_byte ? PH_COLLECT : PH_DRAIN;
          end
        end else if (item_i.last_byte) begin
          produces_o = 1'b1;
          req_o.err  = 1'b1;
          if (fire_i) begin
            hs_we = hdr_wr_en;
            cnt_d = '0;
            lo_d  = '0;
            hi_d  = '0;
          end
        end else if (fire_i) begin
          hs_we = hdr_wr_en;
          cnt_d = cnt_inc;
          lo_d  = lo_new;
          hi_d  = hi_new;
        end
      end
      PH_DRAIN: begin
        if (fire_i && item_i.last_byte) begin
          phase_d = PH_COLLECT;
        end
      end
      default: begin
        phase_d = PH_COLLECT;
        cnt_d   = '0;
        lo_d    = '0;
        hi_d    = '0;
      end
    endcase
    req_o.load = fire_i && produces_o;
    if (cfg_write_i) begin
      phase_d = PH_COLLECT;
      cnt_d   = '0;
      lo_d    = '0;
      hi_d    = '0;
      hs_we   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COLLECT;
      cnt_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hs_we) begin
      hs_q[hs_idx] <= item_i.data_byte;
    end
  end

endmodule

// ----- rtl/sef16_emitter.sv -----
// result register: one status or an eight-byte header burst, one per transaction
// depends on sef16_pkg
`timescale 1ns / 1ps

module sef16_emitter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sef16_pkg::cfg_t      cfg_i,
  input  sef16_pkg::res_req_t  req_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sef16_pkg::out_item_t out_data_o
);

  localparam int unsigned REM_W = $clog2(sef16_pkg::HDR_LEN + 1);

  logic [REM_W-1:0]                rem_q, rem_d;
  logic [sef16_pkg::HDR_IDX_W-1:0] idx_q, idx_d;
  logic                            burst_q, err_q;
  logic [7:0]                      lo_q, hi_q, hdr_byte;
  logic                            take;

  assign take   = out_valid_o && !out_stall_i;
  assign free_o = (rem_q == '0) || ((rem_q == REM_W'(1)) && take);

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (take) begin
      rem_d = rem_q - REM_W'(1);
      idx_d = idx_q + sef16_pkg::HDR_IDX_W'(1);
    end
    if (req_i.load) begin
      rem_d = req_i.burst ? REM_W'(sef16_pkg::HDR_LEN) : REM_W'(1);
      idx_d = '0;
    end
  end

  always_comb begin
    case (idx_q)
      3'd0:    hdr_byte = sef16_pkg::HDR_MAGIC0;
      3'd1:    hdr_byte = sef16_pkg::HDR_MAGIC1;
      3'd2:    hdr_byte = cfg_i.format_version;
      3'd3:    hdr_byte = sef16_pkg::HDR_FLAGS;
      3'd4:    hdr_byte = cfg_i.payload_length[7:0];
      3'd5:    hdr_byte = cfg_i.payload_length[15:8];
      3'd6:    hdr_byte = lo_q;
      default: hdr_byte = hi_q;
    endcase
  end

  assign out_valid_o          = (rem_q != '0);
  assign out_data_o.out_byte  = burst_q ? hdr_byte : 8'h00;
  assign out_data_o.status    = err_q;
  assign out_data_o.final_res = !burst_q || (rem_q == REM_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      burst_q <= req_i.burst;
      err_q   <= req_i.err;
      lo_q    <= req_i.sum_low;
      hi_q    <= req_i.sum_high;
    end
  end

endmodule

// ----- rtl/sef16_checker.sv -----
// port-level checks on the result channel of the framer/checker
// depends on sef16_pkg; bound to save_envelope_fletcher16_core
`timescale 1ns / 1ps

module sef16_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input sef16_pkg::out_item_t out_data_o
);

  // error results carry no header byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.out_byte == 8'h00)
    else $error("error result with non-zero byte");

  // an error always closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.final_res)
    else $error("error result not marked final");

  // a header burst is not broken up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.final_res && !out_stall_i |=> out_valid_o)
    else $error("header burst interrupted");

  // stalled transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind save_envelope_fletcher16_core sef16_checker u_sef16_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- bench/tb_save_envelope_fletcher16_core.sv -----
// testbench for the fletcher-16 record envelope framer/checker, with its own envelope predictor
// depends on sef16_pkg and save_envelope_fletcher16_core
`timescale 1ns / 1ps

module tb_save_envelope_fletcher16_core;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 160;

  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_BUILD = 1'b1;

  localparam logic [sef16_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {RUN_COLLECT, RUN_DRAIN} run_phase_e;
  typedef enum int {REC_CLEAN, REC_TRAILING, REC_FLAWED, REC_SHORT, REC_NOISE} rec_kind_e;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  sef16_pkg::in_item_t              in_data_i   = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  sef16_pkg::out_item_t             out_data_o;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [sef16_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [sef16_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  save_envelope_fletcher16_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sef16_pkg::in_item_t  byte_q[$];
  sef16_pkg::out_item_t reply_q[$];
  logic        in_fire     = 1'b0;
  int unsigned tx_gap_pct  = 0;
  int unsigned rx_hold_pct = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  logic        gen_mode = MODE_CHECK;
  logic [15:0] gen_len  = 16'd1;
  logic [7:0]  gen_ver  = 8'd1;
  int unsigned queued_bytes = 0;

  logic        p_mode = MODE_CHECK;
  logic [15:0] p_len  = 16'd1;
  logic [7:0]  p_ver  = 8'd1;
  logic [16:0] run_count = '0;
  logic [7:0]  fl_lo = '0;
  logic [7:0]  fl_hi = '0;
  logic [7:0]  hdr_seen [sef16_pkg::HDR_LEN];
  run_phase_e  run_phase = RUN_COLLECT;

  int unsigned errors       = 0;
  int unsigned bytes_in     = 0;
  int unsigned results_seen = 0;
  int unsigned io_errors    = 0;
  int unsigned reg_writes   = 0;
  int unsigned cycles       = 0;

  function automatic logic [7:0] fold255(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, b};
    return (s >= 9'd255) ? 8'(s - 9'd255) : s[7:0];
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  task automatic restart_run();
    run_count = '0;
    fl_lo     = '0;
    fl_hi     = '0;
    run_phase = RUN_COLLECT;
  endtask

  task automatic close_run(input logic last_seen);
    restart_run();
    if (!last_seen) begin
      run_phase = RUN_DRAIN;
    end
  endtask

  task automatic queue_reply(input logic [7:0] b, input logic st, input logic fin);
    sef16_pkg::out_item_t r;
    r.out_byte  = b;
    r.status    = st;
    r.final_res = fin;
    reply_q.push_back(r);
  endtask

  // envelope predictor: one accepted byte in, any header bytes or status out
  task automatic fletcher_step(input sef16_pkg::in_item_t it);
    logic [16:0] target;
    logic        bad;
    if (run_phase == RUN_DRAIN) begin
      if (it.last_byte) begin
        restart_run();
      end
    end else if (p_mode == MODE_BUILD && p_len == 16'd0) begin
      queue_reply(8'h00, 1'b1, 1'b1);
      close_run(it.last_byte);
    end else begin
      target = (p_mode == MODE_BUILD) ? {1'b0, p_len} : {1'b0, p_len} + 17'd8;
      if (p_mode == MODE_CHECK && run_count < 17'd8) begin
        hdr_seen[run_count[2:0]] = it.data_byte;
      end else begin
        fl_lo = fold255(fl_lo, it.data_byte);
        fl_hi = fold255(fl_hi, fl_lo);
      end
      run_count = run_count + 17'd1;
      if (run_count == target) begin
        if (p_mode == MODE_BUILD) begin
          queue_reply(sef16_pkg::HDR_MAGIC0, 1'b0, 1'b0);
          queue_reply(sef16_pkg::HDR_MAGIC1, 1'b0, 1'b0);
          queue_reply(p_ver,                 1'b0, 1'b0);
          queue_reply(sef16_pkg::HDR_FLAGS,  1'b0, 1'b0);
          queue_reply(p_len[7:0],            1'b0, 1'b0);
          queue_reply(p_len[15:8],           1'b0, 1'b0);
          queue_reply(fl_lo,                 1'b0, 1'b0);
          queue_reply(fl_hi,                 1'b0, 1'b1);
        end else begin
          // flags byte deliberately left out of the comparison
          bad = (hdr_seen[0] != sef16_pkg::HDR_MAGIC0) ||
                (hdr_seen[1] != sef16_pkg::HDR_MAGIC1) ||
                (hdr_seen[2] != p_ver) || (hdr_seen[4] != p_len[7:0]) ||
                (hdr_seen[5] != p_len[15:8]) || (hdr_seen[6] != fl_lo) ||
                (hdr_seen[7] != fl_hi);
          queue_reply(8'h00, bad, 1'b1);
        end
        close_run(it.last_byte);
      end else if (it.last_byte) begin
        queue_reply(8'h00, 1'b1, 1'b1);
        restart_run();
      end
    end
  endtask

  // monitor: results first, so a result never meets the prediction of the same edge
  always @(posedge clk_i) begin
    sef16_pkg::out_item_t want;
    in_fire <= in_valid_i && !in_stall_o;
    if (!rst_ni) begin
      p_mode = MODE_CHECK;
      p_len  = 16'd1;
      p_ver  = 8'd1;
      restart_run();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (reply_q.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_data_o), 32'd0);
        end else begin
          want = reply_q.pop_front();
          if (want.status) begin
            io_errors++;
          end
          if (out_data_o.out_byte != want.out_byte) begin
            report_mismatch("out_byte", 32'(out_data_o.out_byte), 32'(want.out_byte));
          end
          if (out_data_o.status != want.status) begin
            report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
          end
          if (out_data_o.final_res != want.final_res) begin
            report_mismatch("final_res", 32'(out_data_o.final_res), 32'(want.final_res));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sef16_pkg::CFG_MODE:    p_mode = cfg_data_i[0];
          sef16_pkg::CFG_LENGTH:  p_len  = cfg_data_i[15:0];
          sef16_pkg::CFG_VERSION: p_ver  = cfg_data_i[7:0];
          default: ;
        endcase
        restart_run();
      end
      if (in_valid_i && !in_stall_o) begin
        bytes_in++;
        fletcher_step(in_data_i);
      end
    end
  end

  // byte driver: a new transaction only once the previous one has gone
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
        in_data_i  <= byte_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side back-pressure, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_hold_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, reply_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic l);
    sef16_pkg::in_item_t it;
    it.data_byte = b;
    it.last_byte = l;
    byte_q.push_back(it);
    queued_bytes++;
  endtask

  task automatic settle();
    do @(posedge clk_i); while (byte_q.size() != 0 || in_valid_i || reply_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [sef16_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sef16_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_config(input logic m, input logic [15:0] len, input logic [7:0] ver);
    settle();
    write_reg(sef16_pkg::CFG_MODE, {15'($urandom), m});
    write_reg(sef16_pkg::CFG_LENGTH, len);
    write_reg(sef16_pkg::CFG_VERSION, {8'($urandom), ver});
    gen_mode = m;
    gen_len  = len;
    gen_ver  = ver;
  endtask

  // one record for the current setting, well formed or broken as asked
  task automatic queue_record(input rec_kind_e kind);
    logic [7:0]  body[$];
    logic [7:0]  lo;
    logic [7:0]  hi;
    int unsigned total;
    int unsigned cut;
    int unsigned extra;
    lo = '0;
    hi = '0;
    if (kind == REC_NOISE) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'($urandom));
      push_byte(8'($urandom), 1'b1);
      return;
    end
    for (int i = 0; i < gen_len; i++) begin
      body.push_back(8'($urandom));
      lo = fold255(lo, body[i]);
      hi = fold255(hi, lo);
    end
    if (gen_mode == MODE_CHECK) begin
      body.push_front(hi);
      body.push_front(lo);
      body.push_front(gen_len[15:8]);
      body.push_front(gen_len[7:0]);
      body.push_front(8'($urandom));
      body.push_front(gen_ver);
      body.push_front(sef16_pkg::HDR_MAGIC1);
      body.push_front(sef16_pkg::HDR_MAGIC0);
      if (kind == REC_FLAWED) begin
        body[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
      end
    end else if (gen_len == 16'd0) begin
      body.push_back(8'($urandom));
    end
    total = body.size();
    if (kind == REC_SHORT && total > 1) begin
      cut = (total > 16) ? $urandom_range(1, 16) : $urandom_range(1, total - 1);
      for (int i = 0; i < cut; i++) begin
        push_byte(body[i], i == cut - 1);
      end
    end else begin
      extra = (kind == REC_TRAILING) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < total; i++) begin
        push_byte(body[i], extra == 0 && i == total - 1);
      end
      for (int j = 1; j <= extra; j++) begin
        push_byte(8'($urandom), j == extra);
      end
    end
  endtask

  task automatic random_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                              input int unsigned budget);
    int unsigned start;
    logic [15:0] len;
    logic [7:0]  ver;
    rec_kind_e   kind;
    tx_gap_pct  = gap_pct;
    rx_hold_pct = stall_pct;
    start = queued_bytes;
    while (queued_bytes - start < budget) begin
      len = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 7));
      case ($urandom_range(0, 3))
        0:       ver = 8'h00;
        1:       ver = 8'hFF;
        default: ver = 8'($urandom);
      endcase
      set_config(!gen_mode, len, ver);
      repeat ($urandom_range(2, 4)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: kind = REC_CLEAN;
          5:             kind = REC_TRAILING;
          6, 7:          kind = REC_FLAWED;
          8:             kind = REC_SHORT;
          default:       kind = REC_NOISE;
        endcase
        queue_record(kind);
        // now and then the sender waits for every result of what went before
        if ($urandom_range(0, 3) == 0) begin
          settle();
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setting: check, length 1, version 1; payload 0xff folds both sums to zero
    push_byte(sef16_pkg::HDR_MAGIC0, 1'b0);
    push_byte(sef16_pkg::HDR_MAGIC1, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // stream ends early
    push_byte(8'h00, 1'b1);
    settle();

    // empty payload check, flags byte set and still accepted
    write_reg(sef16_pkg::CFG_LENGTH, 16'h0000);
    push_byte(sef16_pkg::HDR_MAGIC0, 1'b0);
    push_byte(sef16_pkg::HDR_MAGIC1, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();

    // empty payload build fails, then the rest of the stream drains
    write_reg(sef16_pkg::CFG_MODE, 16'h0001);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b1);
    settle();

    write_reg(sef16_pkg::CFG_LENGTH, 16'h0001);
    write_reg(sef16_pkg::CFG_VERSION, 16'h00FF);
    write_reg(CFG_SPARE, 16'($urandom));
    gen_mode = MODE_BUILD;
    gen_len  = 16'd1;
    gen_ver  = 8'hFF;
    push_byte(8'hFF, 1'b1);
    // completing byte without last, trailing byte ignored
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b1);

    random_phase(12, 48, 30);
    random_phase(48, 12, 30);
    random_phase(0, 0, 30);

    // long receiver hold-off while builds keep arriving
    set_config(MODE_BUILD, 16'd2, 8'($urandom));
    hold_req++;
    repeat (8) queue_record(REC_CLEAN);

    // widest length: a check record and a build record, both cut short
    set_config(MODE_CHECK, 16'hFFFF, 8'($urandom));
    queue_record(REC_SHORT);
    set_config(MODE_BUILD, 16'hFFFF, 8'($urandom));
    queue_record(REC_SHORT);
    settle();

    $display("run covered %0d bytes and %0d results (%0d i/o errors) over %0d register writes",
             bytes_in, results_seen, io_errors, reg_writes);
    $display("check and build modes under mixed idling, a long hold-off and the widest length");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
